// ===== rtl/tsms_pkg.sv =====
// Package for the 32.32 timestamp millisecond arithmetic unit.
// Holds the action codes, the fixed conversion constants and the pipeline stage types.
// No dependencies.
`default_nettype none

package tsms_pkg;

   // Action codes carried with each item.
   typedef enum logic [1:0] {
      ACT_ADD  = 2'd0,
      ACT_SUB  = 2'd1,
      ACT_DIFF = 2'd2
   } action_type;

   // One millisecond in units of 1/2^32 second, truncated.
   localparam logic [31:0] MS_PER_SECOND = 32'd1000;
   localparam logic [31:0] FRAC_PER_MS   = 32'd4294967;

   // Exact division of a 32-bit count by 1000: (n * DIV_MAGIC) >> DIV_SHIFT.
   localparam logic [31:0] DIV_MAGIC = 32'd2199023256;
   localparam int          DIV_SHIFT = 41;
   localparam int          WHOLE_W   = 64 - DIV_SHIFT;

   // Remainders and millisecond quotients of a fraction fit in ten bits.
   localparam int          MS_W      = 10;

   // Input register.
   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] a_seconds;
      logic [31:0] a_fraction;
      logic [31:0] b_seconds;
      logic [31:0] b_fraction;
      logic [31:0] delay_ms;
   } s1_type;

   // After the compare and the reciprocal product.
   typedef struct packed {
      logic [1:0]         action;
      logic [31:0]        a_seconds;
      logic [31:0]        a_fraction;
      logic [31:0]        delay_ms;
      logic [WHOLE_W-1:0] whole;
      logic               less;
      logic               equal;
      logic               greater;
      logic [31:0]        mag_seconds;
      logic [31:0]        mag_fraction;
   } s2_type;

   // After the remainder and the seconds scaling.
   typedef struct packed {
      logic [1:0]         action;
      logic [31:0]        a_seconds;
      logic [31:0]        a_fraction;
      logic [WHOLE_W-1:0] whole;
      logic [MS_W-1:0]    rem;
      logic               less;
      logic               equal;
      logic               greater;
      logic [31:0]        sec_ms;
      logic [31:0]        mag_fraction;
      logic [MS_W-1:0]    q_est;
   } s3_type;

   // After the fraction step and the corrected quotient.
   typedef struct packed {
      logic [1:0]         action;
      logic [31:0]        a_seconds;
      logic [31:0]        a_fraction;
      logic [WHOLE_W-1:0] whole;
      logic [31:0]        step;
      logic               less;
      logic               equal;
      logic               greater;
      logic [31:0]        sec_ms;
      logic [MS_W-1:0]    q;
   } s4_type;

endpackage

`default_nettype wire

// ===== rtl/timestamp_ms_arithmetic.sv =====
// Top level of the 32.32 timestamp millisecond arithmetic unit.
// Five-stage pipeline with valid/stall handshakes; depends on tsms_pkg.
//
// This unit takes one item per cycle while the result side does not stall
// and returns the results in the order the items were accepted. Each item
// passes through five registered stages: the input register, which takes
// the item at the accepting edge, the reciprocal product that splits the
// millisecond count into seconds, the remainder, the fraction step and
// quotient correction, and the result register. Each stage holds its item
// while the next one is full and stalled, so items keep entering until
// every stage is occupied. Add mode adds the
// millisecond count to A with carry into the seconds, subtract mode removes it
// with a floor at zero seconds, and difference mode gives A minus B in
// milliseconds. The less, equal and greater flags compare A with B in every
// mode. Unused action codes give zero results with valid flags.
`default_nettype none

module timestamp_ms_arithmetic (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_action,
   input  wire logic [31:0]        req_a_seconds,
   input  wire logic [31:0]        req_a_fraction,
   input  wire logic [31:0]        req_b_seconds,
   input  wire logic [31:0]        req_b_fraction,
   input  wire logic [31:0]        req_delay_ms,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [31:0]             rsp_res_seconds,
   output logic [31:0]             rsp_res_fraction,
   output logic signed [31:0]      rsp_diff_ms,
   output logic                    rsp_a_less,
   output logic                    rsp_a_equal,
   output logic                    rsp_a_greater
);

   localparam int WW = tsms_pkg::WHOLE_W;
   localparam int MW = tsms_pkg::MS_W;

   // Stage occupancy and load enables.
   logic [5:1] valid_ff;
   logic [5:1] load;

   tsms_pkg::s1_type s1_ff, s1_in;
   tsms_pkg::s2_type s2_ff, s2_in;
   tsms_pkg::s3_type s3_ff, s3_in;
   tsms_pkg::s4_type s4_ff, s4_in;

   logic [31:0] res_seconds_ff, res_seconds_in;
   logic [31:0] res_fraction_ff, res_fraction_in;
   logic [31:0] diff_ms_ff, diff_ms_in;
   logic        less_ff, equal_ff, greater_ff;
   logic [1:0]  action_ff;

   // A stage loads when it is empty or its item moves on.
   always_comb begin
      load[5] = !valid_ff[5] || !rsp_stall;
      load[4] = !valid_ff[4] || load[5];
      load[3] = !valid_ff[3] || load[4];
      load[2] = !valid_ff[2] || load[3];
      load[1] = !valid_ff[1] || load[2];
   end

   assign req_stall = !load[1];
   assign rsp_valid = valid_ff[5];

   // Occupancy follows the item from stage to stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (load[1]) valid_ff[1] <= req_valid;
         if (load[2]) valid_ff[2] <= valid_ff[1];
         if (load[3]) valid_ff[3] <= valid_ff[2];
         if (load[4]) valid_ff[4] <= valid_ff[3];
         if (load[5]) valid_ff[5] <= valid_ff[4];
      end
   end

   // Stage 1: input register.
   always_comb begin
      s1_in.action     = req_action;
      s1_in.a_seconds  = req_a_seconds;
      s1_in.a_fraction = req_a_fraction;
      s1_in.b_seconds  = req_b_seconds;
      s1_in.b_fraction = req_b_fraction;
      s1_in.delay_ms   = req_delay_ms;
   end

   // Stage 2: compare A with B, form both differences, split the delay.
   logic [63:0] div_prod;
   logic        seconds_same, borrow_ab, borrow_ba;
   logic [31:0] ab_fraction, ba_fraction, ab_seconds, ba_seconds;

   always_comb begin
      div_prod     = {32'd0, s1_ff.delay_ms} * {32'd0, tsms_pkg::DIV_MAGIC};
      seconds_same = s1_ff.a_seconds == s1_ff.b_seconds;
      borrow_ab    = s1_ff.a_fraction < s1_ff.b_fraction;
      borrow_ba    = s1_ff.b_fraction < s1_ff.a_fraction;
      ab_fraction  = s1_ff.a_fraction - s1_ff.b_fraction;
      ba_fraction  = s1_ff.b_fraction - s1_ff.a_fraction;
      // A borrow from the fraction lowers the seconds by one.
      ab_seconds   = s1_ff.a_seconds + ~s1_ff.b_seconds + {31'd0, !borrow_ab};
      ba_seconds   = s1_ff.b_seconds + ~s1_ff.a_seconds + {31'd0, !borrow_ba};

      s2_in.action     = s1_ff.action;
      s2_in.a_seconds  = s1_ff.a_seconds;
      s2_in.a_fraction = s1_ff.a_fraction;
      s2_in.delay_ms   = s1_ff.delay_ms;
      s2_in.whole      = div_prod[63:tsms_pkg::DIV_SHIFT];
      s2_in.less       = seconds_same ? borrow_ab : (s1_ff.a_seconds < s1_ff.b_seconds);
      s2_in.greater    = seconds_same ? borrow_ba : (s1_ff.a_seconds > s1_ff.b_seconds);
      s2_in.equal      = seconds_same && (s1_ff.a_fraction == s1_ff.b_fraction);
      // Magnitude is taken from the later timestamp minus the earlier one.
      s2_in.mag_seconds  = s2_in.greater ? ab_seconds : ba_seconds;
      s2_in.mag_fraction = s2_in.greater ? ab_fraction : ba_fraction;
   end

   // Stage 3: remainder of the delay, seconds in milliseconds, quotient estimate.
   logic [31:0] whole_scaled, rem_full;
   logic [41:0] frac_prod;

   always_comb begin
      whole_scaled = {{(32-WW){1'b0}}, s2_ff.whole} * tsms_pkg::MS_PER_SECOND;
      rem_full     = s2_ff.delay_ms - whole_scaled;
      frac_prod    = {10'd0, s2_ff.mag_fraction} * {10'd0, tsms_pkg::MS_PER_SECOND};

      s3_in.action       = s2_ff.action;
      s3_in.a_seconds    = s2_ff.a_seconds;
      s3_in.a_fraction   = s2_ff.a_fraction;
      s3_in.whole        = s2_ff.whole;
      s3_in.rem          = rem_full[MW-1:0];
      s3_in.less         = s2_ff.less;
      s3_in.equal        = s2_ff.equal;
      s3_in.greater      = s2_ff.greater;
      s3_in.sec_ms       = s2_ff.mag_seconds * tsms_pkg::MS_PER_SECOND;
      s3_in.mag_fraction = s2_ff.mag_fraction;
      // fraction * 1000 / 2^32 is the true quotient or one below it.
      s3_in.q_est        = frac_prod[41:32];
   end

   // Stage 4: fraction step of the delay and the corrected quotient.
   logic [31:0] q_scaled, q_resid;

   always_comb begin
      q_scaled = {{(32-MW){1'b0}}, s3_ff.q_est} * tsms_pkg::FRAC_PER_MS;
      q_resid  = s3_ff.mag_fraction - q_scaled;

      s4_in.action     = s3_ff.action;
      s4_in.a_seconds  = s3_ff.a_seconds;
      s4_in.a_fraction = s3_ff.a_fraction;
      s4_in.whole      = s3_ff.whole;
      s4_in.step       = {{(32-MW){1'b0}}, s3_ff.rem} * tsms_pkg::FRAC_PER_MS;
      s4_in.less       = s3_ff.less;
      s4_in.equal      = s3_ff.equal;
      s4_in.greater    = s3_ff.greater;
      s4_in.sec_ms     = s3_ff.sec_ms;
      s4_in.q          = (q_resid >= tsms_pkg::FRAC_PER_MS) ? s3_ff.q_est + MW'(1)
                                                            : s3_ff.q_est;
   end

   // Stage 5: final add, subtract with floor, or signed difference.
   logic [31:0] whole_ext, sub_fraction, add_seconds, sub_seconds, magnitude;
   logic [32:0] add_sum;
   logic        sub_borrow, sub_floor;

   always_comb begin
      whole_ext    = {{(32-WW){1'b0}}, s4_ff.whole};
      add_sum      = {1'b0, s4_ff.a_fraction} + {1'b0, s4_ff.step};
      add_seconds  = s4_ff.a_seconds + whole_ext + {31'd0, add_sum[32]};
      sub_borrow   = s4_ff.step > s4_ff.a_fraction;
      sub_fraction = s4_ff.a_fraction - s4_ff.step;
      sub_seconds  = s4_ff.a_seconds + ~whole_ext + {31'd0, !sub_borrow};
      sub_floor    = s4_ff.a_seconds <= whole_ext;
      magnitude    = s4_ff.sec_ms + {{(32-MW){1'b0}}, s4_ff.q};

      res_seconds_in  = '0;
      res_fraction_in = '0;
      diff_ms_in      = '0;
      unique case (s4_ff.action)
         tsms_pkg::ACT_ADD: begin
            res_seconds_in  = add_seconds;
            res_fraction_in = add_sum[31:0];
         end
         tsms_pkg::ACT_SUB: begin
            // At or below the removed seconds the result floors at zero seconds.
            if (sub_floor) begin
               res_seconds_in  = '0;
               res_fraction_in = (s4_ff.step >= s4_ff.a_fraction) ? '0 : sub_fraction;
            end else begin
               res_seconds_in  = sub_seconds;
               res_fraction_in = sub_fraction;
            end
         end
         tsms_pkg::ACT_DIFF: begin
            if (s4_ff.greater) begin
               diff_ms_in = magnitude;
            end else if (s4_ff.less) begin
               diff_ms_in = 32'd0 - magnitude;
            end
         end
         default: begin
            diff_ms_in = '0;
         end
      endcase
   end

   // Payload registers, each loaded with its stage.
   always_ff @(posedge clock) begin
      if (load[1]) s1_ff <= s1_in;
      if (load[2]) s2_ff <= s2_in;
      if (load[3]) s3_ff <= s3_in;
      if (load[4]) s4_ff <= s4_in;
      if (load[5]) begin
         res_seconds_ff  <= res_seconds_in;
         res_fraction_ff <= res_fraction_in;
         diff_ms_ff      <= diff_ms_in;
         less_ff         <= s4_ff.less;
         equal_ff        <= s4_ff.equal;
         greater_ff      <= s4_ff.greater;
         action_ff       <= s4_ff.action;
      end
   end

   assign rsp_res_seconds  = res_seconds_ff;
   assign rsp_res_fraction = res_fraction_ff;
   assign rsp_diff_ms      = $signed(diff_ms_ff);
   assign rsp_a_less       = less_ff;
   assign rsp_a_equal      = equal_ff;
   assign rsp_a_greater    = greater_ff;

   // Exactly one ordering flag holds for every delivered result.
   a_flags_onehot: assert property (@(posedge clock) disable iff (reset)
      valid_ff[5] |-> $onehot({less_ff, equal_ff, greater_ff}))
      else $error("ordering flags are not one-hot");

   // Only add and subtract produce a timestamp; only difference produces milliseconds.
   a_result_zero: assert property (@(posedge clock) disable iff (reset)
      valid_ff[5] && (action_ff != tsms_pkg::ACT_ADD) && (action_ff != tsms_pkg::ACT_SUB)
      |-> (res_seconds_ff == '0) && (res_fraction_ff == '0))
      else $error("timestamp result not zero outside add and subtract");

   a_diff_zero: assert property (@(posedge clock) disable iff (reset)
      valid_ff[5] && (action_ff != tsms_pkg::ACT_DIFF) |-> (diff_ms_ff == '0))
      else $error("difference not zero outside difference mode");

   // The division by 1000 leaves a remainder below 1000.
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] |-> ({{(32-MW){1'b0}}, s3_ff.rem} < tsms_pkg::MS_PER_SECOND))
      else $error("delay remainder out of range");

   // The corrected fraction quotient never exceeds 1000 milliseconds.
   a_q_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[4] |-> ({{(32-MW){1'b0}}, s4_ff.q} <= tsms_pkg::MS_PER_SECOND))
      else $error("fraction quotient out of range");

endmodule

`default_nettype wire

// ===== tb/sv/tb_timestamp_ms_arithmetic.sv =====
// Self-checking testbench for the 32.32 timestamp millisecond arithmetic unit.
// Drives all four action codes with bursty valid and a patterned stall,
// and checks every result against a built-in predictor; depends on tsms_pkg and the RTL.
`default_nettype none

module tb_timestamp_ms_arithmetic;

   // The action code that the unit does not define.
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES = 20;
   localparam int RANDOM_ITEMS = 400;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic [1:0]  action;
      logic [31:0] a_seconds;
      logic [31:0] a_fraction;
      logic [31:0] b_seconds;
      logic [31:0] b_fraction;
      logic [31:0] delay_ms;
      bit          drain_first;
   } stamp_item_type;

   typedef struct {
      logic [31:0] res_seconds;
      logic [31:0] res_fraction;
      logic [31:0] diff_ms;
      logic        a_less;
      logic        a_equal;
      logic        a_greater;
   } stamp_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_action = tsms_pkg::ACT_ADD;
   logic [31:0] req_a_seconds = '0;
   logic [31:0] req_a_fraction = '0;
   logic [31:0] req_b_seconds = '0;
   logic [31:0] req_b_fraction = '0;
   logic [31:0] req_delay_ms = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [31:0] rsp_res_seconds;
   logic [31:0] rsp_res_fraction;
   logic signed [31:0] rsp_diff_ms;
   logic rsp_a_less;
   logic rsp_a_equal;
   logic rsp_a_greater;

   stamp_item_type pending_items[$];
   stamp_result_type predicted_results[$];
   stamp_item_type offered_item;

   int items_queued = 0;
   int items_accepted = 0;
   int results_checked = 0;
   int mismatch_count = 0;
   int burst_left = 0;
   int gap_left = 0;
   int idle_cycles = 0;
   int cycle_count = 0;
   int action_count[4] = '{0, 0, 0, 0};
   int floor_count = 0;
   int earlier_count = 0;
   int equal_count = 0;
   int later_count = 0;

   timestamp_ms_arithmetic DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_a_seconds(req_a_seconds),
      .req_a_fraction(req_a_fraction),
      .req_b_seconds(req_b_seconds),
      .req_b_fraction(req_b_fraction),
      .req_delay_ms(req_delay_ms),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_res_seconds(rsp_res_seconds),
      .rsp_res_fraction(rsp_res_fraction),
      .rsp_diff_ms(rsp_diff_ms),
      .rsp_a_less(rsp_a_less),
      .rsp_a_equal(rsp_a_equal),
      .rsp_a_greater(rsp_a_greater)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Milliseconds from the earlier timestamp to the later one, wrapped to 32 bits.
   function automatic logic [31:0] ms_between(logic [31:0] later_s, logic [31:0] later_f,
                                              logic [31:0] earlier_s, logic [31:0] earlier_f);
      logic [31:0] span_s;
      logic [31:0] span_f;
      span_s = later_s - earlier_s;
      span_f = later_f - earlier_f;
      if (later_f < earlier_f) begin
         span_s = span_s - 32'd1;
      end
      return span_s * tsms_pkg::MS_PER_SECOND + span_f / tsms_pkg::FRAC_PER_MS;
   endfunction

   // Result of one timestamp item.
   function automatic stamp_result_type compute_timestamp_result(stamp_item_type it);
      stamp_result_type r;
      logic [31:0] whole;
      logic [31:0] step;
      r.res_seconds = '0;
      r.res_fraction = '0;
      r.diff_ms = '0;
      whole = it.delay_ms / tsms_pkg::MS_PER_SECOND;
      step = (it.delay_ms % tsms_pkg::MS_PER_SECOND) * tsms_pkg::FRAC_PER_MS;
      if (it.a_seconds == it.b_seconds) begin
         r.a_less = it.a_fraction < it.b_fraction;
         r.a_greater = it.a_fraction > it.b_fraction;
      end else begin
         r.a_less = it.a_seconds < it.b_seconds;
         r.a_greater = it.a_seconds > it.b_seconds;
      end
      r.a_equal = (it.a_seconds == it.b_seconds) && (it.a_fraction == it.b_fraction);
      case (it.action)
         tsms_pkg::ACT_ADD: begin
            r.res_fraction = it.a_fraction + step;
            r.res_seconds = it.a_seconds + whole;
            if (r.res_fraction < it.a_fraction) begin
               r.res_seconds = r.res_seconds + 32'd1;
            end
         end
         tsms_pkg::ACT_SUB: begin
            if (it.a_seconds > whole) begin
               r.res_seconds = it.a_seconds - whole;
               r.res_fraction = it.a_fraction - step;
               if (step > it.a_fraction) begin
                  r.res_seconds = r.res_seconds - 32'd1;
               end
            end else begin
               // Floor at zero seconds, fraction saturates at zero.
               r.res_seconds = '0;
               r.res_fraction = (step >= it.a_fraction) ? 32'd0 : it.a_fraction - step;
            end
         end
         tsms_pkg::ACT_DIFF: begin
            if (r.a_greater) begin
               r.diff_ms = ms_between(it.a_seconds, it.a_fraction, it.b_seconds, it.b_fraction);
            end else if (r.a_less) begin
               r.diff_ms = 32'd0 - ms_between(it.b_seconds, it.b_fraction,
                                             it.a_seconds, it.a_fraction);
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   task automatic queue_item(logic [1:0] act, logic [31:0] as, logic [31:0] af,
                             logic [31:0] bs, logic [31:0] bf, logic [31:0] ms,
                             bit drain);
      stamp_item_type it;
      it.action = act;
      it.a_seconds = as;
      it.a_fraction = af;
      it.b_seconds = bs;
      it.b_fraction = bf;
      it.delay_ms = ms;
      it.drain_first = drain;
      pending_items.push_back(it);
      items_queued++;
   endtask

   // Random item, weighted toward carries, borrows, the floor and near timestamps.
   task automatic queue_random_item(bit drain);
      logic [1:0] act;
      logic [31:0] as;
      logic [31:0] af;
      logic [31:0] bs;
      logic [31:0] bf;
      logic [31:0] ms;
      int pick;
      pick = $urandom_range(0, 99);
      act = (pick < 30) ? tsms_pkg::ACT_ADD :
            (pick < 62) ? tsms_pkg::ACT_SUB :
            (pick < 95) ? tsms_pkg::ACT_DIFF : ACT_UNUSED;
      case ($urandom_range(0, 4))
         0: ms = $urandom();
         1: ms = $urandom_range(0, 999);
         2: ms = $urandom_range(0, 4294967) * tsms_pkg::MS_PER_SECOND;
         3: ms = $urandom_range(0, 100000);
         default: ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
      endcase
      case ($urandom_range(0, 4))
         0: as = $urandom();
         1: as = $urandom_range(0, 20);
         2: as = 32'hFFFF_FFFF - $urandom_range(0, 20);
         3: as = ms / tsms_pkg::MS_PER_SECOND + $urandom_range(0, 1);
         default: as = ms / tsms_pkg::MS_PER_SECOND - $urandom_range(0, 1);
      endcase
      case ($urandom_range(0, 4))
         0: af = 32'd0;
         1: af = 32'hFFFF_FFFF;
         2: af = $urandom_range(0, 1000) * tsms_pkg::FRAC_PER_MS + $urandom_range(0, 2) - 1;
         default: af = $urandom();
      endcase
      case ($urandom_range(0, 5))
         0: begin
            bs = $urandom();
            bf = $urandom();
         end
         1: begin
            bs = as;
            bf = af;
         end
         2: begin
            bs = as;
            bf = $urandom();
         end
         3: begin
            bs = as + $urandom_range(0, 3000);
            bf = $urandom();
         end
         default: begin
            bs = as - $urandom_range(0, 3000);
            bf = $urandom();
         end
      endcase
      queue_item(act, as, af, bs, bf, ms, drain);
   endtask

   // Stimulus: directed corners, then random items, then wait for the last results.
   initial begin
      queue_item(tsms_pkg::ACT_ADD, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
      queue_item(tsms_pkg::ACT_ADD, '1, '1, '1, '1, '1, 1'b0);
      queue_item(tsms_pkg::ACT_ADD, 32'd7, 32'hFFFF_FFFF, 32'd3, 32'd0, 32'd1, 1'b0);
      queue_item(tsms_pkg::ACT_ADD, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd999, 1'b0);
      queue_item(tsms_pkg::ACT_SUB, 32'd5, 32'd10, 32'd5, 32'd10, 32'd5000, 1'b0);
      queue_item(tsms_pkg::ACT_SUB, 32'd0, 32'd100, 32'd1, 32'd0, 32'd7, 1'b0);
      queue_item(tsms_pkg::ACT_SUB, 32'd0, 32'd3 * tsms_pkg::FRAC_PER_MS, 32'd0, 32'd0,
                 32'd3, 1'b0);
      queue_item(tsms_pkg::ACT_SUB, 32'd2, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd3001, 1'b0);
      queue_item(tsms_pkg::ACT_SUB, 32'd10, 32'd0, 32'd10, 32'd1, 32'd1, 1'b0);
      queue_item(tsms_pkg::ACT_SUB, '1, '1, '1, '1, '1, 1'b0);
      queue_item(tsms_pkg::ACT_SUB, 32'd100, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd1500, 1'b0);
      queue_item(tsms_pkg::ACT_SUB, 32'd0, 32'd0, 32'd0, 32'd0, '1, 1'b0);
      queue_item(tsms_pkg::ACT_DIFF, 32'd42, 32'd99, 32'd42, 32'd99, 32'd0, 1'b0);
      queue_item(tsms_pkg::ACT_DIFF, 32'd10, 32'd0, 32'd9, 32'hFFFF_FFFF, 32'd0, 1'b0);
      queue_item(tsms_pkg::ACT_DIFF, 32'd9, 32'd5, 32'd10, 32'd5, 32'd0, 1'b0);
      queue_item(tsms_pkg::ACT_DIFF, 32'd1, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd0, 1'b0);
      queue_item(tsms_pkg::ACT_DIFF, 32'd1, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd0, 1'b0);
      queue_item(tsms_pkg::ACT_DIFF, '1, '1, 32'd0, 32'd0, '1, 1'b0);
      queue_item(tsms_pkg::ACT_DIFF, 32'd0, 32'd0, '1, '1, 32'd0, 1'b0);
      queue_item(tsms_pkg::ACT_DIFF, 32'd3, 32'd0, 32'd2, 32'hFFFF_FFFF, 32'd0, 1'b0);
      queue_item(ACT_UNUSED, '1, '1, 32'd0, 32'd0, '1, 1'b0);
      queue_item(ACT_UNUSED, 32'd0, 32'd0, '1, '1, 32'd0, 1'b0);
      queue_item(ACT_UNUSED, 32'd8, 32'd8, 32'd8, 32'd8, 32'd8, 1'b0);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         queue_random_item(i % 100 == 0);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (results_checked < items_queued) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      mismatch_count += predicted_results.size();

      $display("Checked %0d results: %0d add, %0d subtract, %0d difference, %0d unused code.",
               results_checked, action_count[tsms_pkg::ACT_ADD],
               action_count[tsms_pkg::ACT_SUB], action_count[tsms_pkg::ACT_DIFF],
               action_count[ACT_UNUSED]);
      $display("Subtract floor items %0d; A earlier/equal/later %0d/%0d/%0d.",
               floor_count, earlier_count, equal_count, later_count);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Driver: offers queued items in bursts, holding each until it is accepted.
   always @(posedge clock) begin
      stamp_result_type r;
      bit take_next;
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = $urandom_range(1, 40);
         gap_left = 0;
      end else begin
         take_next = 1'b1;
         if (req_valid && !req_stall) begin
            r = compute_timestamp_result(offered_item);
            predicted_results.push_back(r);
            items_accepted++;
            action_count[offered_item.action]++;
            if (offered_item.action == tsms_pkg::ACT_SUB &&
                offered_item.a_seconds <= offered_item.delay_ms / tsms_pkg::MS_PER_SECOND) begin
               floor_count++;
            end
            earlier_count += r.a_less;
            equal_count += r.a_equal;
            later_count += r.a_greater;
         end else if (req_valid) begin
            take_next = 1'b0;
         end
         if (take_next) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0 &&
                         !(pending_items[0].drain_first && predicted_results.size() > 0)) begin
               offered_item = pending_items.pop_front();
               req_valid <= 1'b1;
               req_action <= offered_item.action;
               req_a_seconds <= offered_item.a_seconds;
               req_a_fraction <= offered_item.a_fraction;
               req_b_seconds <= offered_item.b_seconds;
               req_b_fraction <= offered_item.b_fraction;
               req_delay_ms <= offered_item.delay_ms;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("Result %0d: %s expected 0x%08h, got 0x%08h",
                     results_checked, field, want, got);
         end
      end
   endtask

   // Monitor: checks each accepted result and drives the stall pattern.
   always @(posedge clock) begin
      stamp_result_type want;
      cycle_count++;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("Unexpected result: seconds 0x%08h fraction 0x%08h diff %0d",
                           rsp_res_seconds, rsp_res_fraction, rsp_diff_ms);
               end
            end else begin
               want = predicted_results.pop_front();
               check_field("res_seconds", want.res_seconds, rsp_res_seconds);
               check_field("res_fraction", want.res_fraction, rsp_res_fraction);
               check_field("diff_ms", want.diff_ms, rsp_diff_ms);
               check_field("a_less", {31'd0, want.a_less}, {31'd0, rsp_a_less});
               check_field("a_equal", {31'd0, want.a_equal}, {31'd0, rsp_a_equal});
               check_field("a_greater", {31'd0, want.a_greater}, {31'd0, rsp_a_greater});
               results_checked++;
            end
         end
         // The stall pattern steps through four modes in turn: none, random, periodic, long holds.
         case ((cycle_count / 97) % 4)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= (cycle_count % 5 < 2);
            default: rsp_stall <= (cycle_count % 23 < 15);
         endcase
      end
   end

   // Watchdog: ends the run when neither channel moves an item for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/tsms_pkg.sv
rtl/timestamp_ms_arithmetic.sv
tb/sv/tb_timestamp_ms_arithmetic.sv
